/* design/assert_macros.svh */
// assertion macros for the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define DHT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dht assertion failed");

// next-cycle implication, disabled during reset
`define DHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dht assertion failed");

`endif

/* design/dht_pkg.sv */
// types and constants of the double hashing table unit
package dht_pkg;

  localparam int KEY_W  = 31;
  localparam int SIZE_W = 11;
  localparam int SLOT_W = 10;
  localparam int KOUT_W = 32;

  localparam int SIZE_MIN = 2;
  localparam int SIZE_RST = 1024;
  localparam int SIZE_CAP = 2 ** SIZE_W - 1;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_SEARCH = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_READ   = 2'd3
  } dht_func_e;

  localparam logic [1:0] ST_EMPTY   = 2'd0;
  localparam logic [1:0] ST_FILLED  = 2'd1;
  localparam logic [1:0] ST_REMOVED = 2'd2;

  localparam logic [1:0] RC_OK        = 2'd0;
  localparam logic [1:0] RC_NOT_FOUND = 2'd1;
  localparam logic [1:0] RC_FULL      = 2'd2;

  localparam logic signed [KOUT_W-1:0] KEY_NONE = -32'sd1;

  typedef struct packed {
    dht_func_e             func;
    logic [KEY_W-1:0]      key;
    logic [SLOT_W-1:0]     slot_index;
  } dht_req_t;

  typedef struct packed {
    logic [1:0]                result_code;
    logic [SLOT_W-1:0]         slot;
    logic signed [KOUT_W-1:0]  key_out;
    logic [1:0]                slot_state;
  } dht_rsp_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [KEY_W-1:0] key;
  } dht_entry_t;

  typedef struct packed {
    logic              start;
    logic [KEY_W-1:0]  dividend;
    logic [SIZE_W-1:0] divisor;
  } dht_mod_req_t;

  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] rem;
  } dht_mod_rsp_t;

endpackage

/* design/dht_mod_unit.sv */
// bit-serial restoring remainder unit, one key bit per cycle
module dht_mod_unit import dht_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  dht_mod_req_t req_i,
  output dht_mod_rsp_t rsp_o
);

  localparam int CNT_W = $clog2(KEY_W);

  logic              run_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [KEY_W-1:0]  k_q;
  logic [SIZE_W-1:0] d_q;
  logic [SIZE_W-1:0] r_q;
  logic [SIZE_W:0]   trial;
  logic [SIZE_W-1:0] r_d;

  always_comb begin
    trial = {r_q, k_q[KEY_W-1]};
    if (trial >= {1'b0, d_q}) begin
      r_d = SIZE_W'(trial - {1'b0, d_q});
    end else begin
      r_d = SIZE_W'(trial);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(KEY_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      k_q <= req_i.dividend;
      d_q <= req_i.divisor;
      r_q <= '0;
    end else if (run_q) begin
      k_q <= k_q << 1;
      r_q <= r_d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.rem  = r_q;

endmodule

/* design/double_hash_table_unit.sv */
// double hashing table: sequencer, slot memory and result register
//
// One operation at a time. Insert, search and remove first work out
// key mod m and key mod (m - 1) on one shared bit-serial remainder unit,
// one after the other, then probe the slot memory, each probe a read
// followed by a check that may write; read slot reads the addressed entry
// and returns its state and key.
// After reset and after every table_size write, a clearing pass marks all
// SLOTS entries empty at one entry per cycle, and busy stays high for the
// whole pass. busy is also high in any cycle with a table_size write.
// Each result shows on rsp_o for one cycle with result_valid_o and must be
// taken then; a new start may be accepted in that same cycle.
module double_hash_table_unit import dht_pkg::*; #(
  parameter int SLOTS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  dht_req_t          req_i,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i,
  output logic              result_valid_o,
  output dht_rsp_t          rsp_o
);

  localparam int IDX_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int SIZE_MAX  = (SLOTS < SIZE_CAP) ? SLOTS : SIZE_CAP;
  localparam int SIZE_INIT = (SIZE_RST < SIZE_MAX) ? SIZE_RST : SIZE_MAX;

  localparam logic [2:0] S_CLEAR      = 3'd0;
  localparam logic [2:0] S_IDLE       = 3'd1;
  localparam logic [2:0] S_MOD_A      = 3'd2;
  localparam logic [2:0] S_MOD_B      = 3'd3;
  localparam logic [2:0] S_PROBE_ADDR = 3'd4;
  localparam logic [2:0] S_PROBE_CHK  = 3'd5;
  localparam logic [2:0] S_READ_ADDR  = 3'd6;
  localparam logic [2:0] S_READ_CHK   = 3'd7;

  logic [2:0]        state_q, state_d;
  logic [SIZE_W-1:0] size_q, size_d;
  logic [IDX_W-1:0]  clr_q, clr_d;
  logic              valid_q, valid_d;
  dht_func_e         func_q, func_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic [SIZE_W-1:0] j_q, j_d;
  logic [SIZE_W-1:0] step_q, step_d;
  logic [SIZE_W-1:0] cnt_q, cnt_d;
  dht_rsp_t          rsp_q, rsp_d;

  dht_entry_t        mem_q [SLOTS];
  dht_entry_t        rd_q;
  logic              mem_we;
  logic [IDX_W-1:0]  mem_waddr;
  logic [IDX_W-1:0]  mem_raddr;
  dht_entry_t        mem_wdata;

  dht_mod_req_t      mod_req;
  dht_mod_rsp_t      mod_rsp;

  logic              accept;
  logic [SIZE_W-1:0] size_wr;
  logic [IDX_W-1:0]  addr_j;
  logic [SIZE_W:0]   j_sum;
  logic [SIZE_W-1:0] j_next;
  logic              is_filled;
  logic              hit;
  logic              last;
  logic              in_range;
  logic [1:0]        rd_state;

  dht_mod_unit u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  assign busy   = (state_q != S_IDLE) || cfg_we_i;
  assign accept = start && !busy;
  assign addr_j = IDX_W'(j_q);

  always_comb begin
    if (cfg_wdata_i < SIZE_W'(SIZE_MIN)) begin
      size_wr = SIZE_W'(SIZE_MIN);
    end else if (32'(cfg_wdata_i) > 32'(SIZE_MAX)) begin
      size_wr = SIZE_W'(SIZE_MAX);
    end else begin
      size_wr = cfg_wdata_i;
    end
  end

  always_comb begin
    j_sum = {1'b0, j_q} + {1'b0, step_q};
    if (j_sum >= {1'b0, size_q}) begin
      j_next = SIZE_W'(j_sum - {1'b0, size_q});
    end else begin
      j_next = SIZE_W'(j_sum);
    end
    is_filled = (rd_q.status == ST_FILLED);
    hit       = is_filled && (rd_q.key == key_q);
    last      = (cnt_q == size_q - SIZE_W'(1));
    in_range  = (32'(idx_q) < 32'(SLOTS));
    rd_state  = in_range ? rd_q.status : ST_EMPTY;
  end

  always_comb begin
    state_d   = state_q;
    size_d    = size_q;
    clr_d     = clr_q;
    valid_d   = 1'b0;
    func_d    = func_q;
    key_d     = key_q;
    idx_d     = idx_q;
    j_d       = j_q;
    step_d    = step_q;
    cnt_d     = cnt_q;
    rsp_d     = rsp_q;
    mem_we    = 1'b0;
    mem_waddr = addr_j;
    mem_raddr = addr_j;
    mem_wdata = rd_q;
    mod_req   = '0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        if (clr_q == IDX_W'(SLOTS - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + IDX_W'(1);
        end
      end
      S_IDLE: begin
        if (accept) begin
          func_d = req_i.func;
          key_d  = req_i.key;
          idx_d  = req_i.slot_index;
          if (req_i.func == FUNC_READ) begin
            state_d = S_READ_ADDR;
          end else begin
            mod_req.start    = 1'b1;
            mod_req.dividend = req_i.key;
            mod_req.divisor  = size_q;
            state_d          = S_MOD_A;
          end
        end
      end
      S_MOD_A: begin
        if (mod_rsp.done) begin
          j_d              = mod_rsp.rem;
          mod_req.start    = 1'b1;
          mod_req.dividend = key_q;
          mod_req.divisor  = size_q - SIZE_W'(1);
          state_d          = S_MOD_B;
        end
      end
      S_MOD_B: begin
        if (mod_rsp.done) begin
          step_d  = mod_rsp.rem + SIZE_W'(1);
          cnt_d   = '0;
          state_d = S_PROBE_ADDR;
        end
      end
      S_PROBE_ADDR: begin
        mem_raddr = addr_j;
        state_d   = S_PROBE_CHK;
      end
      S_PROBE_CHK: begin
        if (func_q == FUNC_INSERT) begin
          priority if (!is_filled) begin
            mem_we           = 1'b1;
            mem_wdata.status = ST_FILLED;
            mem_wdata.key    = key_q;
            rsp_d            = '0;
            rsp_d.slot       = SLOT_W'(j_q);
            valid_d          = 1'b1;
            state_d          = S_IDLE;
          end else if (last) begin
            rsp_d             = '0;
            rsp_d.result_code = RC_FULL;
            valid_d           = 1'b1;
            state_d           = S_IDLE;
          end else begin
            cnt_d   = cnt_q + SIZE_W'(1);
            j_d     = j_next;
            state_d = S_PROBE_ADDR;
          end
        end else begin
          priority if (hit) begin
            if (func_q == FUNC_REMOVE) begin
              mem_we           = 1'b1;
              mem_wdata.status = ST_REMOVED;
              mem_wdata.key    = rd_q.key;
            end
            rsp_d      = '0;
            rsp_d.slot = SLOT_W'(j_q);
            valid_d    = 1'b1;
            state_d    = S_IDLE;
          end else if ((rd_q.status == ST_EMPTY) || last) begin
            rsp_d             = '0;
            rsp_d.result_code = RC_NOT_FOUND;
            valid_d           = 1'b1;
            state_d           = S_IDLE;
          end else begin
            cnt_d   = cnt_q + SIZE_W'(1);
            j_d     = j_next;
            state_d = S_PROBE_ADDR;
          end
        end
      end
      S_READ_ADDR: begin
        mem_raddr = IDX_W'(idx_q);
        state_d   = S_READ_CHK;
      end
      S_READ_CHK: begin
        rsp_d            = '0;
        rsp_d.slot       = idx_q;
        rsp_d.slot_state = rd_state;
        rsp_d.key_out    = (rd_state == ST_FILLED) ? $signed({1'b0, rd_q.key}) : KEY_NONE;
        valid_d          = 1'b1;
        state_d          = S_IDLE;
      end
    endcase

    if (cfg_we_i) begin
      size_d  = size_wr;
      clr_d   = '0;
      state_d = S_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      size_q  <= SIZE_W'(SIZE_INIT);
      clr_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      size_q  <= size_d;
      clr_q   <= clr_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q <= func_d;
    key_q  <= key_d;
    idx_q  <= idx_d;
    j_q    <= j_d;
    step_q <= step_d;
    cnt_q  <= cnt_d;
    rsp_q  <= rsp_d;
  end

  // slot memory, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[mem_raddr];
  end

  assign result_valid_o = valid_q;
  assign rsp_o          = rsp_q;

endmodule

/* design/dht_checker.sv */
// port-level checker for the double hashing table unit, with its bind
`include "assert_macros.svh"

module dht_checker import dht_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     start,
  input logic     busy,
  input logic     cfg_we_i,
  input logic     result_valid_o,
  input dht_rsp_t rsp_o
);

  logic code_known;
  logic result_miss;

  assign code_known  = (rsp_o.result_code == RC_OK) ||
                       (rsp_o.result_code == RC_NOT_FOUND) ||
                       (rsp_o.result_code == RC_FULL);
  assign result_miss = result_valid_o && (rsp_o.result_code != RC_OK);

  `DHT_ASSERT_NEXT(a_single_result, clk_i, rst_ni, result_valid_o, !result_valid_o)

  `DHT_ASSERT_NEXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy)

  `DHT_ASSERT_NEXT(a_cfg_clear, clk_i, rst_ni, cfg_we_i, busy)

  `DHT_ASSERT_IMPLY(a_code_known, clk_i, rst_ni, result_valid_o, code_known)

  `DHT_ASSERT_IMPLY(a_miss_slot, clk_i, rst_ni, result_miss, rsp_o.slot == '0)

endmodule

bind double_hash_table_unit dht_checker u_dht_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .cfg_we_i       (cfg_we_i),
  .result_valid_o (result_valid_o),
  .rsp_o          (rsp_o)
);

/* tb/dht_result_checker.sv */
// checker for the double hashing table unit: table predictor and response scoreboard
`timescale 1ns / 100ps

module dht_result_checker import dht_pkg::*; #(
  parameter int SLOTS = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic              busy_i,
  input  dht_req_t          req_i,
  input  logic              cfg_we_i,
  input  logic [SIZE_W-1:0] cfg_wdata_i,
  input  logic              result_valid_i,
  input  dht_rsp_t          rsp_i,
  output int                pending_o,
  output int                errors_o
);

  logic [1:0]       slot_status [SLOTS];
  logic [KEY_W-1:0] slot_key    [SLOTS];
  int unsigned      table_m;
  dht_rsp_t         rsp_expected_q [$];

  function automatic int unsigned clamp_size(int unsigned v);
    if (v < SIZE_MIN) return SIZE_MIN;
    if (v > SLOTS) return SLOTS;
    return v;
  endfunction

  function automatic void clear_table();
    foreach (slot_status[i]) slot_status[i] = ST_EMPTY;
  endfunction

  function automatic int find_key(logic [KEY_W-1:0] k);
    int unsigned j;
    int unsigned step;
    j    = k % table_m;
    step = 1 + k % (table_m - 1);
    for (int unsigned i = 0; i < table_m; i++) begin
      if (slot_status[j] == ST_FILLED && slot_key[j] == k) return j;
      if (slot_status[j] == ST_EMPTY) return -1;
      j = j + step;
      if (j >= table_m) j = j - table_m;
    end
    return -1;
  endfunction

  function automatic int claim_slot(logic [KEY_W-1:0] k);
    int unsigned j;
    int unsigned step;
    j    = k % table_m;
    step = 1 + k % (table_m - 1);
    for (int unsigned i = 0; i < table_m; i++) begin
      if (slot_status[j] != ST_FILLED) begin
        slot_status[j] = ST_FILLED;
        slot_key[j]    = k;
        return j;
      end
      j = j + step;
      if (j >= table_m) j = j - table_m;
    end
    return -1;
  endfunction

  function automatic dht_rsp_t predict_rsp(dht_req_t r);
    dht_rsp_t rsp;
    int       j;
    rsp = '0;
    case (r.func)
      FUNC_INSERT: begin
        j = claim_slot(r.key);
        if (j < 0) rsp.result_code = RC_FULL;
        else rsp.slot = j[SLOT_W-1:0];
      end
      FUNC_SEARCH, FUNC_REMOVE: begin
        j = find_key(r.key);
        if (j < 0) begin
          rsp.result_code = RC_NOT_FOUND;
        end else begin
          rsp.slot = j[SLOT_W-1:0];
          if (r.func == FUNC_REMOVE) slot_status[j] = ST_REMOVED;
        end
      end
      default: begin
        rsp.slot       = r.slot_index;
        rsp.key_out    = KEY_NONE;
        rsp.slot_state = ST_EMPTY;
        if (r.slot_index < SLOTS) rsp.slot_state = slot_status[r.slot_index];
        if (rsp.slot_state == ST_FILLED) rsp.key_out = {1'b0, slot_key[r.slot_index]};
      end
    endcase
    return rsp;
  endfunction

  function automatic int compare_rsp(dht_rsp_t want, dht_rsp_t got);
    int bad;
    bad = 0;
    if (got.result_code !== want.result_code) begin
      $error("result_code expected %0d actual %0d", want.result_code, got.result_code);
      bad++;
    end
    if (got.slot !== want.slot) begin
      $error("slot expected %0d actual %0d", want.slot, got.slot);
      bad++;
    end
    if (got.key_out !== want.key_out) begin
      $error("key_out expected %0d actual %0d", want.key_out, got.key_out);
      bad++;
    end
    if (got.slot_state !== want.slot_state) begin
      $error("slot_state expected %0d actual %0d", want.slot_state, got.slot_state);
      bad++;
    end
    return bad;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_m = clamp_size(SIZE_RST);
      clear_table();
      rsp_expected_q.delete();
      pending_o <= 0;
    end else begin
      if (cfg_we_i) begin
        table_m = clamp_size(cfg_wdata_i);
        clear_table();
      end
      if (result_valid_i) begin
        if (rsp_expected_q.size() == 0) begin
          $error("result with no transaction outstanding");
          errors_o = errors_o + 1;
        end else begin
          errors_o = errors_o + compare_rsp(rsp_expected_q.pop_front(), rsp_i);
        end
      end
      if (start_i && !busy_i) rsp_expected_q.push_back(predict_rsp(req_i));
      pending_o <= rsp_expected_q.size();
    end
  end

endmodule

/* tb/tb_double_hash_table_unit.sv */
// testbench top for the double hashing table unit: stimulus, watchdog and verdict
`timescale 1ns / 100ps

module tb_double_hash_table_unit;
  import dht_pkg::*;

  localparam int SLOTS      = 1024;
  localparam int QUIET_MAX  = 20000;
  localparam int PHASES     = 10;
  localparam int PHASE_OPS  = 48;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  dht_req_t          req;
  logic              cfg_we;
  logic [SIZE_W-1:0] cfg_wdata;
  logic              result_valid;
  dht_rsp_t          rsp;
  int                pending;
  int                errors;
  int                quiet_cycles;
  bit                gaps_on;
  logic [KEY_W-1:0]  key_pool [6];

  double_hash_table_unit #(.SLOTS(SLOTS)) u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .req_i          (req),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .result_valid_o (result_valid),
    .rsp_o          (rsp)
  );

  dht_result_checker #(.SLOTS(SLOTS)) u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .req_i          (req),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .result_valid_i (result_valid),
    .rsp_i          (rsp),
    .pending_o      (pending),
    .errors_o       (errors)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || result_valid || cfg_we) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= QUIET_MAX) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic send_op(input dht_func_e f, input logic [KEY_W-1:0] k,
                         input logic [SLOT_W-1:0] idx);
    dht_req_t r;
    int       gap;
    r.func       = f;
    r.key        = k;
    r.slot_index = idx;
    gap = 0;
    if (gaps_on && $urandom_range(99) < 27)
      gap = ($urandom_range(9) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 4);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // hold off until every outstanding transaction has returned
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] v);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic run_phase(input logic [SIZE_W-1:0] size_val);
    int unsigned      m;
    int unsigned      pick;
    dht_func_e        f;
    logic [KEY_W-1:0] k;
    logic [SLOT_W-1:0] idx;
    m = (size_val < SIZE_MIN) ? SIZE_MIN : (size_val > SLOTS) ? SLOTS : size_val;
    write_size(size_val);
    foreach (key_pool[i])
      key_pool[i] = $urandom_range(1) ? KEY_W'($urandom_range(0, 4095)) : KEY_W'($urandom);
    for (int n = 0; n < PHASE_OPS; n++) begin
      pick = $urandom_range(99);
      f = (pick < 40) ? FUNC_INSERT : (pick < 65) ? FUNC_SEARCH :
          (pick < 85) ? FUNC_REMOVE : FUNC_READ;
      k = ($urandom_range(99) < 80) ? key_pool[$urandom_range(5)] : KEY_W'($urandom);
      idx = ($urandom_range(99) < 70) ? SLOT_W'($urandom_range(0, m - 1))
                                      : SLOT_W'($urandom_range(0, SLOTS - 1));
      send_op(f, k, idx);
      if ($urandom_range(49) == 0) drain();
    end
  endtask

  initial begin
    logic [SIZE_W-1:0] size_val;
    rst_n        = 1'b0;
    start        = 1'b0;
    req          = '0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    gaps_on      = 1'b1;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset size: basic insert, search, remove and read
    send_op(FUNC_READ,   '0,          '0);
    send_op(FUNC_INSERT, '0,          '0);
    send_op(FUNC_INSERT, '1,          '0);
    send_op(FUNC_READ,   '0,          '1);
    send_op(FUNC_SEARCH, '1,          '0);
    send_op(FUNC_REMOVE, '1,          '0);
    send_op(FUNC_SEARCH, '1,          '0);
    send_op(FUNC_READ,   '0,          '1);
    send_op(FUNC_INSERT, '0,          '0);
    send_op(FUNC_SEARCH, 31'd12345,   10'h2aa);
    send_op(FUNC_READ,   31'h2aaaaaaa, 10'h155);

    // size below minimum, fill to full
    write_size('0);
    send_op(FUNC_INSERT, 31'd5, '0);
    send_op(FUNC_INSERT, 31'd5, '0);
    send_op(FUNC_INSERT, 31'd9, '0);
    send_op(FUNC_SEARCH, 31'd9, '0);
    send_op(FUNC_REMOVE, 31'd5, '0);
    send_op(FUNC_READ,   '0,    10'd1);
    send_op(FUNC_INSERT, 31'd4, '0);
    send_op(FUNC_READ,   '0,    10'd5);
    send_op(FUNC_READ,   '0,    '1);

    // size above maximum saturates
    write_size('1);
    send_op(FUNC_INSERT, 31'd2047, '0);
    send_op(FUNC_READ,   '0,       '1);
    write_size(11'd1);
    send_op(FUNC_INSERT, 31'd3,    '0);

    for (int p = 0; p < PHASES; p++) begin
      if (p == 0) begin
        size_val = 11'd2;
      end else if (p == PHASES - 1) begin
        size_val = 11'd1024;
      end else begin
        case ($urandom_range(5))
          0: size_val = 11'd2;
          1: size_val = 11'd3;
          2: size_val = SIZE_W'($urandom_range(4, 16));
          3: size_val = SIZE_W'($urandom_range(17, 128));
          4: size_val = 11'd1024;
          default: size_val = SIZE_W'($urandom_range(1025, 2047));
        endcase
      end
      gaps_on = (p != 4);
      run_phase(size_val);
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
